@@ rtl/swmac_pkg.sv @@
package swmac_pkg;

   localparam int COST_W      = 16;
   localparam int QTY_W       = 16;
   localparam int WIN_W       = 10;
   localparam int RATE_W      = 16;
   localparam int HOUR_W      = 20;
   localparam int AGE_W       = 10;
   localparam int BEST_W      = 26;
   localparam int PROD_W      = BEST_W + QTY_W;
   localparam int TOTAL_W     = 64;
   localparam int OUT_TOTAL_W = 63;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HOURS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDING_RATE = 2'd1;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [HOUR_W-1:0] hour;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRONT,
      ST_BACK,
      ST_PUSH,
      ST_MUL,
      ST_ADD
   } state_type;

endpackage

@@ rtl/swmac_ram.sv @@
module swmac_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/sliding_window_min_with_aging_cost_core.sv @@
// Sliding-window minimum with aging cost. Each transaction on req_ is one hour: its unit
// cost and the quantity ordered. A monotonic deque of past hours lives in a two-read-port
// RAM; an entry's effective cost is its cost plus its age times holding_rate, and entries
// older than window_hours are dropped. Each hour returns one rsp_ transaction with the
// minimum effective cost and the running total of minimum times quantity (low 63 bits of a
// wrapping 64-bit sum). An hour runs front eviction, back pops, push, the cost/quantity
// multiply and the 64-bit add; the front of a full deque is dropped in the step that ends
// the back pops. Pops are amortized to at most one per hour. The accumulate step also waits
// while the previous result is still stalled in the rsp_ register. A finished result sits
// in the rsp_ register while the next hour is taken. csr_ writes take effect at once; the
// user must make them only while the block is idle, and the block does not enforce this.
// No clearing pass after reset.
module sliding_window_min_with_aging_cost_core #(
   parameter int DEQUE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [swmac_pkg::COST_W-1:0]            req_hour_cost,
   input  logic [swmac_pkg::QTY_W-1:0]             req_order_qty,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [swmac_pkg::BEST_W-1:0]            rsp_best_cost,
   output logic [swmac_pkg::OUT_TOTAL_W-1:0]       rsp_running_total,
   input  logic                                    csr_wr_en,
   input  logic [swmac_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [swmac_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PTR_W = $clog2(DEQUE_DEPTH);
   localparam int CNT_W = $clog2(DEQUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEQUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEQUE_DEPTH);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - PTR_W'(1);
   endfunction

   swmac_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0]                    head_ff, head_in;
   logic [PTR_W-1:0]                    tail_ff, tail_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [swmac_pkg::HOUR_W-1:0]        hour_ff, hour_in;
   logic [swmac_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic [swmac_pkg::WIN_W-1:0]         window_ff, window_in;
   logic [swmac_pkg::RATE_W-1:0]        rate_ff, rate_in;
   logic [swmac_pkg::COST_W-1:0]        cost_ff, cost_in;
   logic [swmac_pkg::QTY_W-1:0]         qty_ff, qty_in;
   logic [swmac_pkg::BEST_W-1:0]        best_ff, best_in;
   logic [swmac_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swmac_pkg::BEST_W-1:0]        rsp_best_ff, rsp_best_in;
   logic [swmac_pkg::OUT_TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   logic                                ram_wr_en;
   swmac_pkg::entry_type                ram_wr_data;
   logic [PTR_W-1:0]                    ram_rd_addr_a;
   logic [PTR_W-1:0]                    ram_rd_addr_b;
   swmac_pkg::entry_type                head_entry;
   swmac_pkg::entry_type                back_entry;

   swmac_pkg::entry_type                eff_entry;
   logic [swmac_pkg::HOUR_W-1:0]        head_age;
   logic [swmac_pkg::HOUR_W-1:0]        eff_age;
   logic [swmac_pkg::BEST_W-1:0]        eff_cost;
   logic                                head_stale;
   logic                                rsp_load;

   swmac_ram #(
      .WIDTH ($bits(swmac_pkg::entry_type)),
      .DEPTH (DEQUE_DEPTH)
   ) u_deque_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (tail_ff),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (head_entry),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (back_entry)
   );

   // read addresses follow next-state pointers so data matches the pointer registers
   assign ram_rd_addr_a = head_in;
   assign ram_rd_addr_b = prev_slot(tail_in);
   assign ram_wr_data   = '{cost: cost_ff, hour: hour_ff};

   assign head_age   = hour_ff - head_entry.hour;
   assign head_stale = head_age > swmac_pkg::HOUR_W'(window_ff);

   // one shared aging multiplier: back entry while popping, head entry at push
   assign eff_entry = (state_ff == swmac_pkg::ST_PUSH) ? head_entry : back_entry;
   assign eff_age   = hour_ff - eff_entry.hour;
   assign eff_cost  = swmac_pkg::BEST_W'(eff_entry.cost)
                    + swmac_pkg::BEST_W'(eff_age[swmac_pkg::AGE_W-1:0])
                    * swmac_pkg::BEST_W'(rate_ff);

   assign rsp_load = (state_ff == swmac_pkg::ST_ADD) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      hour_in      = hour_ff;
      total_in     = total_ff;
      window_in    = window_ff;
      rate_in      = rate_ff;
      cost_in      = cost_ff;
      qty_in       = qty_ff;
      best_in      = best_ff;
      prod_in      = prod_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            swmac_pkg::CSR_WINDOW_HOURS: window_in = csr_wdata[swmac_pkg::WIN_W-1:0];
            swmac_pkg::CSR_HOLDING_RATE: rate_in   = csr_wdata[swmac_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         swmac_pkg::ST_IDLE: begin
            if (req_valid) begin
               cost_in  = req_hour_cost;
               qty_in   = req_order_qty;
               state_in = swmac_pkg::ST_FRONT;
            end
         end
         swmac_pkg::ST_FRONT: begin
            if ((count_ff != '0) && head_stale) begin
               head_in  = next_slot(head_ff);
               count_in = count_ff - CNT_W'(1);
            end else begin
               state_in = swmac_pkg::ST_BACK;
            end
         end
         swmac_pkg::ST_BACK: begin
            if ((count_ff != '0) && (eff_cost >= swmac_pkg::BEST_W'(cost_ff))) begin
               tail_in  = prev_slot(tail_ff);
               count_in = count_ff - CNT_W'(1);
            end else begin
               if (count_ff == FULL_CNT) begin
                  head_in  = next_slot(head_ff);
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = swmac_pkg::ST_PUSH;
            end
         end
         swmac_pkg::ST_PUSH: begin
            ram_wr_en = 1'b1;
            tail_in   = next_slot(tail_ff);
            count_in  = count_ff + CNT_W'(1);
            best_in   = (count_ff == '0) ? swmac_pkg::BEST_W'(cost_ff) : eff_cost;
            state_in  = swmac_pkg::ST_MUL;
         end
         swmac_pkg::ST_MUL: begin
            prod_in  = swmac_pkg::PROD_W'(best_ff) * swmac_pkg::PROD_W'(qty_ff);
            state_in = swmac_pkg::ST_ADD;
         end
         swmac_pkg::ST_ADD: begin
            if (rsp_load) begin
               total_in     = total_ff + swmac_pkg::TOTAL_W'(prod_ff);
               rsp_best_in  = best_ff;
               rsp_total_in = total_in[swmac_pkg::OUT_TOTAL_W-1:0];
               rsp_valid_in = 1'b1;
               hour_in      = hour_ff + swmac_pkg::HOUR_W'(1);
               state_in     = swmac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmac_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmac_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         hour_ff      <= '0;
         total_ff     <= '0;
         window_ff    <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         hour_ff      <= hour_in;
         total_ff     <= total_in;
         window_ff    <= window_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff      <= cost_in;
      qty_ff       <= qty_in;
      best_ff      <= best_in;
      prod_ff      <= prod_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_stall         = (state_ff != swmac_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_cost     = rsp_best_ff;
   assign rsp_running_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("deque count exceeds depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty deque with head and tail apart");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == swmac_pkg::ST_FRONT))
      else $error("accepted transaction did not start front eviction");

   a_rsp_from_add: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == swmac_pkg::ST_ADD))
      else $error("response raised outside accumulate step");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmac_pkg::ST_PUSH) |=> (count_ff != '0))
      else $error("deque empty after push");
`endif

endmodule
